>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the attitude rate law design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/qarl_pkg.sv
// ----------------------------------------------------------------------------
// qarl_pkg
// Types and constants shared by the attitude rate law pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qarl_pkg;

    localparam int QW   = 16;   // quaternion / acceleration field width
    localparam int GW   = 16;   // gain register width
    localparam int PW   = 32;   // 16x16 product width
    localparam int SW   = 34;   // sum of four products
    localparam int MW   = 52;   // gain or acceleration times a sum
    localparam int OW   = 18;   // output field width
    localparam int FRAC = 28;   // fraction bits dropped at the output

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_RATE_GAIN = 1'b0;

    localparam logic [GW-1:0] GAIN_RESET = 16'd2560;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [PW-1:0] prd_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [MW-1:0] mul_t;
    typedef logic signed [OW-1:0] out_field_t;

    typedef struct packed {
        q_t cur_w;
        q_t cur_x;
        q_t cur_y;
        q_t cur_z;
        q_t ref_w;
        q_t ref_x;
        q_t ref_y;
        q_t ref_z;
        q_t acc_x;
        q_t acc_y;
        q_t acc_z;
    } item_t;

    // qp[i][j] = cur[i] * ref[j], index 0..3 = w,x,y,z
    // zp: cw*cy, cx*cz, cy*cz, cw*cx, cw*cw, cx*cx, cy*cy, cz*cz
    typedef struct packed {
        prd_t [3:0][3:0] qp;
        prd_t [7:0]      zp;
        q_t              acc_x;
        q_t              acc_y;
        q_t              acc_z;
    } prod_t;

    typedef struct packed {
        sum_t ew;
        sum_t ex;
        sum_t ey;
        sum_t ez;
        sum_t zx;
        sum_t zy;
        sum_t zz;
        q_t   acc_x;
        q_t   acc_y;
        q_t   acc_z;
    } sums_t;

    typedef struct packed {
        mul_t rx;
        mul_t ry;
        mul_t rz;
        mul_t tx;
        mul_t ty;
        mul_t tz;
    } scale_t;

    typedef struct packed {
        out_field_t rate_x;
        out_field_t rate_y;
        out_field_t rate_z;
        out_field_t thrust;
    } result_t;

endpackage

`default_nettype wire

>>> design/qarl_mult.sv
// ----------------------------------------------------------------------------
// qarl_mult
// Stage 1: all 16x16 products for the error quaternion and body z axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qarl_mult (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire qarl_pkg::item_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output qarl_pkg::prod_t     out_data
);

    logic            valid_reg;
    qarl_pkg::prod_t data_reg;
    qarl_pkg::prod_t data_next;
    qarl_pkg::q_t    cq [4];
    qarl_pkg::q_t    rq [4];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        cq[0] = in_data.cur_w;
        cq[1] = in_data.cur_x;
        cq[2] = in_data.cur_y;
        cq[3] = in_data.cur_z;
        rq[0] = in_data.ref_w;
        rq[1] = in_data.ref_x;
        rq[2] = in_data.ref_y;
        rq[3] = in_data.ref_z;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                data_next.qp[i][j] = qarl_pkg::prd_t'(cq[i]) * qarl_pkg::prd_t'(rq[j]);
            end
        end
        data_next.zp[0] = qarl_pkg::prd_t'(cq[0]) * qarl_pkg::prd_t'(cq[2]);
        data_next.zp[1] = qarl_pkg::prd_t'(cq[1]) * qarl_pkg::prd_t'(cq[3]);
        data_next.zp[2] = qarl_pkg::prd_t'(cq[2]) * qarl_pkg::prd_t'(cq[3]);
        data_next.zp[3] = qarl_pkg::prd_t'(cq[0]) * qarl_pkg::prd_t'(cq[1]);
        for (int k = 0; k < 4; k++)
        begin
            data_next.zp[4 + k] = qarl_pkg::prd_t'(cq[k]) * qarl_pkg::prd_t'(cq[k]);
        end
        data_next.acc_x = in_data.acc_x;
        data_next.acc_y = in_data.acc_y;
        data_next.acc_z = in_data.acc_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/qarl_sum.sv
// ----------------------------------------------------------------------------
// qarl_sum
// Stage 2: sums of products -> error quaternion and body z axis, Q.28.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qarl_sum (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qarl_pkg::prod_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output qarl_pkg::sums_t      out_data
);

    logic            valid_reg;
    qarl_pkg::sums_t data_reg;
    qarl_pkg::sums_t data_next;
    qarl_pkg::sum_t  p [4][4];
    qarl_pkg::sum_t  z [8];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p[i][j] = qarl_pkg::sum_t'($signed(in_data.qp[i][j]));
            end
        end
        for (int k = 0; k < 8; k++)
        begin
            z[k] = qarl_pkg::sum_t'($signed(in_data.zp[k]));
        end
        // conj(cur) * ref, with index 0..3 = w,x,y,z
        data_next.ew = p[0][0] + p[1][1] + p[2][2] + p[3][3];
        data_next.ex = p[0][1] - p[1][0] - p[2][3] + p[3][2];
        data_next.ey = p[0][2] + p[1][3] - p[2][0] - p[3][1];
        data_next.ez = p[0][3] - p[1][2] + p[2][1] - p[3][0];
        // third column of the rotation matrix
        data_next.zx = (z[0] + z[1]) <<< 1;
        data_next.zy = (z[2] - z[3]) <<< 1;
        data_next.zz = z[4] - z[5] - z[6] + z[7];
        data_next.acc_x = in_data.acc_x;
        data_next.acc_y = in_data.acc_y;
        data_next.acc_z = in_data.acc_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/qarl_scale.sv
// ----------------------------------------------------------------------------
// qarl_scale
// Stage 3: signed gain times error vector, acceleration times body z axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qarl_scale (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [qarl_pkg::GW-1:0]   gain,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire qarl_pkg::sums_t           in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output qarl_pkg::scale_t               out_data
);

    logic                          valid_reg;
    qarl_pkg::scale_t              data_reg;
    qarl_pkg::scale_t              data_next;
    logic signed [qarl_pkg::GW:0]  gain_pos;
    logic signed [qarl_pkg::GW:0]  gain_sgn;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // negative error scalar flips the gain; zero counts as positive
    assign gain_pos = $signed({1'b0, gain});
    assign gain_sgn = in_data.ew[qarl_pkg::SW-1] ? -gain_pos : gain_pos;

    always_comb
    begin
        data_next.rx = qarl_pkg::mul_t'(gain_sgn) * qarl_pkg::mul_t'(in_data.ex);
        data_next.ry = qarl_pkg::mul_t'(gain_sgn) * qarl_pkg::mul_t'(in_data.ey);
        data_next.rz = qarl_pkg::mul_t'(gain_sgn) * qarl_pkg::mul_t'(in_data.ez);
        data_next.tx = qarl_pkg::mul_t'(in_data.acc_x) * qarl_pkg::mul_t'(in_data.zx);
        data_next.ty = qarl_pkg::mul_t'(in_data.acc_y) * qarl_pkg::mul_t'(in_data.zy);
        data_next.tz = qarl_pkg::mul_t'(in_data.acc_z) * qarl_pkg::mul_t'(in_data.zz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/qarl_out.sv
// ----------------------------------------------------------------------------
// qarl_out
// Stage 4: thrust sum, round to Q.8 and saturate; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qarl_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire qarl_pkg::scale_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output qarl_pkg::result_t     out_data
);

    localparam int RW = qarl_pkg::MW - qarl_pkg::FRAC;

    logic              valid_reg;
    qarl_pkg::result_t data_reg;
    qarl_pkg::result_t data_next;
    qarl_pkg::mul_t    thr_sum;

    // round half up to Q.8, then clamp to the 18-bit range
    function automatic qarl_pkg::out_field_t rnd_sat(input qarl_pkg::mul_t v);
        qarl_pkg::mul_t        t;
        logic signed [RW-1:0]  r;
        qarl_pkg::out_field_t  res;
        t = v + (qarl_pkg::mul_t'(1) <<< (qarl_pkg::FRAC - 1));
        r = RW'(t >>> qarl_pkg::FRAC);
        if (r > RW'(2 ** (qarl_pkg::OW - 1) - 1))
        begin
            res = {1'b0, {(qarl_pkg::OW - 1){1'b1}}};
        end
        else if (r < -(RW'(2 ** (qarl_pkg::OW - 1))))
        begin
            res = {1'b1, {(qarl_pkg::OW - 1){1'b0}}};
        end
        else
        begin
            res = r[qarl_pkg::OW-1:0];
        end
        return res;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign thr_sum = in_data.tx + in_data.ty + in_data.tz;

    always_comb
    begin
        data_next.rate_x = rnd_sat(in_data.rx);
        data_next.rate_y = rnd_sat(in_data.ry);
        data_next.rate_z = rnd_sat(in_data.rz);
        data_next.thrust = rnd_sat(thr_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/quaternion_attitude_rate_law_top.sv
// Path: the four stage registers, product, sum, scale and output, in order.
// Throughput: one request per cycle unless the output stalls; each stage holds
// one request and advances whenever the stage after it is empty or moving.
// Reset: rst_n (asynchronous, active low) empties the pipeline and loads
// rate_gain with 2560 (10.0 in Q8.8). Data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_attitude_rate_law_top
// Quaternion attitude error controller: body rate commands and thrust.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quaternion_attitude_rate_law_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [qarl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [qarl_pkg::DATA_W-1:0]   pwdata,
    output logic      [qarl_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, from bit 0 up: cur_w, cur_x, cur_y, cur_z, ref_w, ref_x,
    // ref_y, ref_z, acc_x, acc_y, acc_z (16 bits each)
    input  wire logic [175:0]                  s_tdata,
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, from bit 0 up: rate_x, rate_y, rate_z, thrust (18 bits each)
    output logic [71:0]                        m_tdata
);

    // ------------------------------------------------------------------
    // Configuration: one register, rate_gain (2/tau, unsigned Q8.8).
    // Index comes from paddr[2]; writes to other indexes are dropped.
    // ------------------------------------------------------------------
    logic [qarl_pkg::GW-1:0] gain_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= qarl_pkg::GAIN_RESET;
        end
        else if (cfg_wr && (paddr[2] == qarl_pkg::REG_RATE_GAIN))
        begin
            gain_reg <= pwdata[qarl_pkg::GW-1:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            qarl_pkg::REG_RATE_GAIN: prdata = {{(qarl_pkg::DATA_W - qarl_pkg::GW){1'b0}}, gain_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Unpack the input request; first field sits in the low bits.
    // ------------------------------------------------------------------
    qarl_pkg::item_t item;

    assign item.cur_w = s_tdata[15:0];
    assign item.cur_x = s_tdata[31:16];
    assign item.cur_y = s_tdata[47:32];
    assign item.cur_z = s_tdata[63:48];
    assign item.ref_w = s_tdata[79:64];
    assign item.ref_x = s_tdata[95:80];
    assign item.ref_y = s_tdata[111:96];
    assign item.ref_z = s_tdata[127:112];
    assign item.acc_x = s_tdata[143:128];
    assign item.acc_y = s_tdata[159:144];
    assign item.acc_z = s_tdata[175:160];

    // ------------------------------------------------------------------
    // Pipeline: products -> sums -> gain/axis multiply -> round, saturate.
    // Ready ripples back one stage at a time, so bubbles are squeezed out
    // even while the output register is stalled.
    // ------------------------------------------------------------------
    qarl_pkg::prod_t   s1_data;
    qarl_pkg::sums_t   s2_data;
    qarl_pkg::scale_t  s3_data;
    qarl_pkg::result_t res;
    logic              s1_valid, s1_ready;
    logic              s2_valid, s2_ready;
    logic              s3_valid, s3_ready;

    qarl_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    qarl_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // the user must change gain only while the pipeline is empty (the block does not enforce this); it is read live
    qarl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    qarl_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {res.thrust, res.rate_z, res.rate_y, res.rate_x};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input back-pressure only ever comes from a stalled output
    `ASSERT_IMPLIES(a_bp_from_out, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // a new result only appears when stage 3 held a request
    `ASSERT_IMPLIES(a_out_from_s3, clk, rst_n, $rose(m_tvalid), $past(s3_valid))
    // a gain write lands in the register
    `ASSERT_NEXT(a_gain_wr, clk, rst_n,
        cfg_wr && (paddr[2] == qarl_pkg::REG_RATE_GAIN),
        gain_reg == $past(pwdata[qarl_pkg::GW-1:0]))

endmodule

`default_nettype wire

>>> tb/rate_law_checker.sv
// ----------------------------------------------------------------------------
// rate_law_checker
// Watches the config port and both streams of the attitude rate law block,
// predicts rate commands and thrust for every accepted request and compares
// each result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rate_law_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qarl_pkg::ADDR_W-1:0]   paddr,
    input  logic [qarl_pkg::DATA_W-1:0]   pwdata,
    input  logic [qarl_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // cur_w, cur_x, cur_y, cur_z, ref_w, ref_x, ref_y, ref_z, acc_x, acc_y, acc_z
    input  logic [175:0]                  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // rate_x, rate_y, rate_z, thrust
    input  logic [71:0]                   m_tdata,
    output int                            mismatch_count,
    output int                            open_requests
);

    localparam longint HALF_LSB = 64'sd1 <<< (qarl_pkg::FRAC - 1);
    localparam longint OUT_HI   = 131071;
    localparam longint OUT_LO   = -131072;

    logic [qarl_pkg::GW-1:0] gain_copy;
    qarl_pkg::result_t       pending_rates [$];
    int                      n_bad  = 0;
    int                      n_open = 0;
    string                   field_name [4] = '{"rate_x", "rate_y", "rate_z", "thrust"};

    assign mismatch_count = n_bad;
    assign open_requests  = n_open;

    // Q.36 down to Q.8, ties toward +inf, then clamp to 18 bits
    function automatic qarl_pkg::out_field_t round_q8(input longint v);
        longint r;
        r = (v + HALF_LSB) >>> qarl_pkg::FRAC;
        if (r > OUT_HI)
            r = OUT_HI;
        else if (r < OUT_LO)
            r = OUT_LO;
        return qarl_pkg::out_field_t'(r[qarl_pkg::OW-1:0]);
    endfunction

    function automatic qarl_pkg::result_t predict_rate_command(
        input logic [175:0]              req,
        input logic [qarl_pkg::GW-1:0]   gain);
        qarl_pkg::q_t      f [11];
        longint            cw, cx, cy, cz, rw, rx, ry, rz, ax, ay, az;
        longint            ew, ex, ey, ez, g, zx, zy, zz, thr;
        qarl_pkg::result_t res;
        for (int i = 0; i < 11; i++)
            f[i] = req[16*i +: 16];
        cw = f[0]; cx = f[1]; cy = f[2];  cz = f[3];
        rw = f[4]; rx = f[5]; ry = f[6];  rz = f[7];
        ax = f[8]; ay = f[9]; az = f[10];
        // conj(cur) * ref
        ew = cw*rw + cx*rx + cy*ry + cz*rz;
        ex = cw*rx - cx*rw - cy*rz + cz*ry;
        ey = cw*ry + cx*rz - cy*rw - cz*rx;
        ez = cw*rz - cx*ry + cy*rx - cz*rw;
        // zero scalar counts as positive
        g = longint'(gain);
        if (ew < 0)
            g = -g;
        // body z axis
        zx = 2 * (cw*cy + cx*cz);
        zy = 2 * (cy*cz - cw*cx);
        zz = cw*cw - cx*cx - cy*cy + cz*cz;
        thr = ax*zx + ay*zy + az*zz;
        res.rate_x = round_q8(g * ex);
        res.rate_y = round_q8(g * ey);
        res.rate_z = round_q8(g * ez);
        res.thrust = round_q8(thr);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        qarl_pkg::result_t    want;
        qarl_pkg::out_field_t want_f [4];
        if (!rst_n)
        begin
            gain_copy = qarl_pkg::GAIN_RESET;
            pending_rates.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_rates.size() == 0)
                begin
                    $error("result 0x%018h with no request outstanding", m_tdata);
                    n_bad++;
                end
                else
                begin
                    want = pending_rates.pop_front();
                    want_f = '{want.rate_x, want.rate_y, want.rate_z, want.thrust};
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[qarl_pkg::OW*i +: qarl_pkg::OW] !== want_f[i])
                        begin
                            $error("%s: expected %0d, actual %0d", field_name[i],
                                   want_f[i],
                                   $signed(m_tdata[qarl_pkg::OW*i +: qarl_pkg::OW]));
                            n_bad++;
                        end
                end
            end
            if (s_tvalid && s_tready)
                pending_rates.push_back(predict_rate_command(s_tdata, gain_copy));
            if (psel && penable && pready && paddr[2] == qarl_pkg::REG_RATE_GAIN)
            begin
                if (pwrite)
                    gain_copy = pwdata[qarl_pkg::GW-1:0];
                else if (prdata !== {{(qarl_pkg::DATA_W-qarl_pkg::GW){1'b0}}, gain_copy})
                begin
                    $error("rate_gain: expected %0d, actual %0d", gain_copy, prdata);
                    n_bad++;
                end
            end
        end
        n_open = pending_rates.size();
    end

endmodule

>>> tb/tb_quaternion_attitude_rate_law_top.sv
// ----------------------------------------------------------------------------
// tb_quaternion_attitude_rate_law_top
// Drives attitude requests and gain settings into the rate law block with
// random stalls on both streams; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_attitude_rate_law_top;

    // byte addresses of the register map; the second one decodes to no register
    localparam logic [qarl_pkg::ADDR_W-1:0] GAIN_ADDR  = 3'd0;
    localparam logic [qarl_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;

    // cycles with no handshake on either stream before the run is abandoned;
    // covers the long receiver hold-off plus config traffic several times over
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 300;

    logic                          clk;
    logic                          rst_n;
    logic                          psel, penable, pwrite;
    logic [qarl_pkg::ADDR_W-1:0]   paddr;
    logic [qarl_pkg::DATA_W-1:0]   pwdata;
    logic [qarl_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_tvalid, s_tready;
    // cur_w, cur_x, cur_y, cur_z, ref_w, ref_x, ref_y, ref_z, acc_x, acc_y, acc_z
    logic [175:0]                  s_tdata;
    logic                          m_tvalid, m_tready;
    // rate_x, rate_y, rate_z, thrust
    logic [71:0]                   m_tdata;

    int mismatch_count;
    int open_requests;

    // stall chances in percent per request / per cycle, and a one-shot
    // receiver hold-off length picked up by the receiver process
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_len = 0;
    int quiet_cycles = 0;

    logic [qarl_pkg::GW-1:0] gain_plan [6] = '{16'd0, 16'd65535, 16'd1, 16'd256,
                                               16'd2560, 16'd0};

    quaternion_attitude_rate_law_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rate_law_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .open_requests  (open_requests)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Config access: setup phase, then access phase until pready, then an idle
    // phase. Entered and left at a falling edge.
    task automatic apb_access(input logic wr, input logic [qarl_pkg::ADDR_W-1:0] addr,
                              input logic [qarl_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one request, optionally after a random gap, and returns at the
    // falling edge after it was taken. valid stays high between back-to-back
    // requests so it is never dropped and raised in one step.
    task automatic offer_request(input qarl_pkg::item_t it);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.acc_z, it.acc_y, it.acc_x, it.ref_z, it.ref_y, it.ref_x,
                     it.ref_w, it.cur_z, it.cur_y, it.cur_x, it.cur_w};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Sender goes quiet until every predicted result has been returned.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (open_requests != 0)
            @(negedge clk);
    endtask

    function automatic qarl_pkg::q_t pick_field(input int style, input bit unit_range);
        qarl_pkg::q_t corners [7] = '{16'sh8000, 16'shC000, 16'shFFFF, 16'sh0000,
                                      16'sh0001, 16'sh4000, 16'sh7FFF};
        if (style >= 8)
            return corners[$urandom_range(0, 6)];
        if (style >= 2 && unit_range)
            return qarl_pkg::q_t'($urandom_range(0, 32768) - 16384);
        return qarl_pkg::q_t'($urandom_range(0, 65535));
    endfunction

    // Mostly quaternions in the nominal Q1.14 span with any acceleration,
    // some fully random patterns, some built from corner values.
    function automatic qarl_pkg::item_t random_attitude();
        qarl_pkg::item_t it;
        int              style;
        style    = $urandom_range(0, 9);
        it.cur_w = pick_field(style, 1'b1);
        it.cur_x = pick_field(style, 1'b1);
        it.cur_y = pick_field(style, 1'b1);
        it.cur_z = pick_field(style, 1'b1);
        it.ref_w = pick_field(style, 1'b1);
        it.ref_x = pick_field(style, 1'b1);
        it.ref_y = pick_field(style, 1'b1);
        it.ref_z = pick_field(style, 1'b1);
        it.acc_x = pick_field(style, 1'b0);
        it.acc_y = pick_field(style, 1'b0);
        it.acc_z = pick_field(style, 1'b0);
        return it;
    endfunction

    // Receiver: ready by default, random stall bursts, and a long one-shot
    // hold-off when the stimulus asks for one. Only this process drives m_tready.
    initial
    begin
        int stall_len;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                stall_len   = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
                stall_len = $urandom_range(1, 17);
            else
                stall_len = 0;
            if (stall_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_len - 1)
                    @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: any handshake on either stream restarts the count.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [qarl_pkg::GW-1:0] gain;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // gain must read back its reset value before anything is written
        apb_access(1'b0, GAIN_ADDR, '0);

        // ---- directed requests at the reset gain (10.0) ----
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        // identity vs identity: zero error, thrust equals acc_z
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0});
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, 16384, 0, 0, 0,
                                        32767, -32768, 32767});
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, 16384, 0, 0, 0,
                                        -32768, 32767, -32768});
        // error scalar exactly zero, sign taken as positive
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, 0, 16384, 0, 0, 256, 256, 256});
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, 0, 0, 16384, 0, -256, 0, 512});
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, 0, 0, 0, 16384, 0, -512, 1});
        // negative error scalar flips the rate sign; the last two have a zero scalar
        offer_request(qarl_pkg::item_t'{16384, 0, 0, 0, -16384, 8192, 0, 0, 0, 0, 2560});
        offer_request(qarl_pkg::item_t'{-16384, 0, 0, 0, 16384, 0, -8192, 4096,
                                        100, 200, 300});
        offer_request(qarl_pkg::item_t'{0, 16384, 0, 0, 16384, 0, 0, 0, 100, 200, 300});
        offer_request(qarl_pkg::item_t'{0, 0, 16384, 0, 0, 0, 0, -16384, -1, -1, -1});
        // raw patterns, several far outside the unit sphere; the first two saturate thrust
        offer_request(qarl_pkg::item_t'{-32768, -32768, -32768, -32768, -32768, -32768,
                                        -32768, -32768, -32768, -32768, -32768});
        offer_request(qarl_pkg::item_t'{32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                        32767, 32767, 32767, 32767});
        offer_request(qarl_pkg::item_t'{16384, 16384, 16384, 16384, -16384, -16384,
                                        -16384, -16384, 32767, -32768, 0});
        offer_request(qarl_pkg::item_t'{11585, 11585, 0, 0, 11585, 0, 11585, 0,
                                        256, -256, 2560});
        offer_request(qarl_pkg::item_t'{0, 0, 0, 16384, 16384, 0, 0, 0,
                                        32767, 32767, 32767});
        offer_request(qarl_pkg::item_t'{-32768, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 32767});
        offer_request(qarl_pkg::item_t'{-32768, -32768, 32767, 0, 1, -1, 32767, -32768,
                                        -32768, 0, 32767});
        // all zero, a zero current quaternion with extreme reference, and tiny values
        offer_request(qarl_pkg::item_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        offer_request(qarl_pkg::item_t'{0, 0, 0, 0, -32768, 32767, -32768, 32767,
                                        1, 1, 1});
        offer_request(qarl_pkg::item_t'{-1, -1, -1, -1, 1, 1, 1, 1, -1, 1, -1});
        settle();

        // ---- random phases, one per gain setting, including both ends ----
        for (int phase = 0; phase < 6; phase++)
        begin
            gain = (phase == 5) ? qarl_pkg::GW'($urandom_range(0, 65535))
                                : gain_plan[phase];
            // idle chance is drawn anew per phase; zero gives stretches with no gaps
            tx_idle_pct = $urandom_range(0, 3) * 10;
            rx_idle_pct = $urandom_range(0, 3) * 10;
            // upper data bits are random and must not land in the register
            apb_access(1'b1, GAIN_ADDR, {16'($urandom), gain});
            apb_access(1'b0, GAIN_ADDR, '0);
            // a write to the unmapped slot leaves the gain untouched
            apb_access(1'b1, SPARE_ADDR, $urandom);
            apb_access(1'b0, GAIN_ADDR, '0);
            repeat (200)
                offer_request(random_attitude());
            settle();
        end

        // ---- back-pressure: receiver holds off while requests keep coming,
        // so the pipeline fills and input ready drops ----
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = HOLD_OFF_LEN;
        repeat (40)
            offer_request(random_attitude());
        settle();

        // ---- final stretch at full rate, no stalls on either side ----
        apb_access(1'b1, GAIN_ADDR, {16'd0, qarl_pkg::GW'($urandom_range(0, 65535))});
        apb_access(1'b0, GAIN_ADDR, '0);
        repeat (250)
            offer_request(random_attitude());
        settle();

        // keep the clock running in case anything extra comes out
        repeat (20)
            @(negedge clk);
        if (mismatch_count == 0 && open_requests == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
